// File: rtl/wlr_pkg.sv
package wlr_pkg;

  localparam int CanvasSize = 1024;
  localparam int CoordBits  = 10;
  localparam int SampleBits = 16;
  localparam int CountBits  = 13;
  localparam int IndexBits  = 12;
  localparam int DivBits    = 26;
  localparam int DenBits    = 16;
  localparam int QueueDepth = 4;
  localparam int QPtrBits   = 2;
  localparam int ErrBits    = 13;

  localparam logic [CoordBits-1:0] CoordMax = CoordBits'(CanvasSize - 1);

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_STEP   = 2'd1,
    CMD_FRAME  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_PLOT_WIDTH   = 3'd0,
    REG_PLOT_HEIGHT  = 3'd1,
    REG_ORIGIN_X     = 3'd2,
    REG_ORIGIN_Y     = 3'd3,
    REG_MIN_VALUE    = 3'd4,
    REG_DATA_RANGE   = 3'd5,
    REG_SAMPLE_COUNT = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    Q_STEP = 2'd0,
    Q_ARM  = 2'd1,
    Q_DROP = 2'd2
  } q_op_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MUL,
    FS_START,
    FS_DIV,
    FS_PUSH
  } front_state_e;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [SampleBits-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
    logic                 segment_end;
    logic                 frame_end;
  } out_item_t;

  typedef struct packed {
    q_op_e                op;
    logic [CoordBits-1:0] x0;
    logic [CoordBits-1:0] y0;
    logic [CoordBits-1:0] x1;
    logic [CoordBits-1:0] y1;
    logic                 last;
  } q_entry_t;

endpackage

// File: rtl/wlr_div.sv
module wlr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wlr_pkg::DivBits-1:0]  num_i,
  input  logic [wlr_pkg::DenBits-1:0]  den_i,
  output logic                         done_o,
  output logic [wlr_pkg::DivBits-1:0]  quot_o,
  output logic                         rem_nz_o
);
  import wlr_pkg::*;

  localparam int CntBits = $clog2(DivBits);
  localparam logic [CntBits-1:0] LastCnt = CntBits'(DivBits - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [DenBits-1:0]  den_q, den_d;
  logic [DenBits-1:0]  rem_q, rem_d;
  logic [DivBits-1:0]  quo_q, quo_d;
  logic [DenBits:0]    rem_sh;
  logic [DenBits:0]    rem_sub;
  logic                fits;

  assign rem_sh  = {rem_q, quo_q[DivBits-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[DenBits-1:0] : rem_sh[DenBits-1:0];
      quo_d = {quo_q[DivBits-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o   = done_q;
  assign quot_o   = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

// File: rtl/wlr_queue.sv
module wlr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wlr_pkg::q_entry_t push_entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output wlr_pkg::q_entry_t head_o
);
  import wlr_pkg::*;

  q_entry_t            mem_q [QueueDepth];
  logic [QPtrBits-1:0] wr_q, wr_d;
  logic [QPtrBits-1:0] rd_q, rd_d;
  logic [QPtrBits:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (QPtrBits+1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPtrBits+1)'(push_i) - (QPtrBits+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

// File: rtl/wlr_front.sv
module wlr_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  wlr_pkg::in_item_t               in_item_i,
  input  logic                            cfg_valid_i,
  input  logic [2:0]                      cfg_index_i,
  input  logic [wlr_pkg::SampleBits-1:0]  cfg_data_i,
  output logic                            push_o,
  output wlr_pkg::q_entry_t               push_entry_o,
  input  logic                            q_full_i
);
  import wlr_pkg::*;

  front_state_e state_q, state_d;

  logic [CoordBits-1:0]         plot_width_q, plot_height_q, origin_x_q, origin_y_q;
  logic signed [SampleBits-1:0] min_value_q;
  logic [SampleBits-1:0]        data_range_q;
  logic [CountBits-1:0]         sample_count_q;

  logic [IndexBits-1:0]         index_q, index_d;
  logic [CoordBits-1:0]         prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic signed [SampleBits:0]   d_q;
  logic [21:0]                  prodx_q;
  logic [DivBits-1:0]           prody_q;
  logic signed [DivBits:0]      half_q;
  logic                         dneg_q;
  logic [CoordBits-1:0]         nx_q, ny_q;

  logic                         in_fire;
  logic                         div_start;
  logic [CountBits-1:0]         sc;
  logic                         last_sample;
  logic [SampleBits-1:0]        d_abs;
  logic signed [DivBits:0]      d_ext, h_ext;
  logic signed [SampleBits:0]   d_new;
  logic                         divx_done, divy_done;
  logic [DivBits-1:0]           quot_x, quot_y;
  logic                         remx_nz, remy_nz;
  logic [DivBits:0]             px;
  logic signed [DivBits+1:0]    qy, py;
  logic [CoordBits-1:0]         nx_new, ny_new;

  always_comb begin
    if (sample_count_q < CountBits'(2)) begin
      sc = CountBits'(2);
    end else if (sample_count_q > CountBits'(4096)) begin
      sc = CountBits'(4096);
    end else begin
      sc = sample_count_q;
    end
  end

  assign last_sample = {1'b0, index_q} >= (sc - 1'b1);
  assign in_ready_o  = (state_q == FS_IDLE) && !q_full_i;
  assign in_fire     = in_valid_i && in_ready_o;

  assign d_new = {in_item_i.sample_value[SampleBits-1], in_item_i.sample_value}
               - {min_value_q[SampleBits-1], min_value_q};
  assign d_abs = d_q[SampleBits] ? SampleBits'(-d_q) : d_q[SampleBits-1:0];
  assign d_ext = {{(DivBits-SampleBits){d_q[SampleBits]}}, d_q};
  assign h_ext = {{(DivBits+1-CoordBits+1){1'b0}}, plot_height_q[CoordBits-1:1]};

  wlr_div u_div_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    ({{(DivBits-22){1'b0}}, prodx_q}),
    .den_i    ({{(DenBits-CountBits){1'b0}}, sc}),
    .done_o   (divx_done),
    .quot_o   (quot_x),
    .rem_nz_o (remx_nz)
  );

  wlr_div u_div_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (prody_q),
    .den_i    (data_range_q),
    .done_o   (divy_done),
    .quot_o   (quot_y),
    .rem_nz_o (remy_nz)
  );

  always_comb begin
    px = {{(DivBits+1-CoordBits){1'b0}}, origin_x_q} + {1'b0, quot_x};
    if (px > {{(DivBits+1-CoordBits){1'b0}}, CoordMax}) begin
      nx_new = CoordMax;
    end else begin
      nx_new = px[CoordBits-1:0];
    end
    if (data_range_q == '0) begin
      qy = {half_q[DivBits], half_q};
    end else if (dneg_q) begin
      qy = -($signed({2'b00, quot_y}) + $signed({{(DivBits+1){1'b0}}, remy_nz}));
    end else begin
      qy = $signed({2'b00, quot_y});
    end
    py = $signed({{(DivBits+2-CoordBits){1'b0}}, origin_y_q})
       + $signed({{(DivBits+2-CoordBits){1'b0}}, plot_height_q}) - qy;
    if (py < 0) begin
      ny_new = '0;
    end else if (py > $signed({{(DivBits+2-CoordBits){1'b0}}, CoordMax})) begin
      ny_new = CoordMax;
    end else begin
      ny_new = py[CoordBits-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: begin
        if (in_fire && in_item_i.command == CMD_SAMPLE) begin
          state_d = FS_MUL;
        end
      end
      FS_MUL:   state_d = FS_START;
      FS_START: state_d = FS_DIV;
      FS_DIV: begin
        if (divx_done && divy_done) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (index_q == '0 || !q_full_i) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    push_o       = 1'b0;
    push_entry_o = '0;
    index_d      = index_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    unique case (state_q)
      FS_IDLE: begin
        if (in_fire) begin
          unique case (in_item_i.command)
            CMD_STEP: begin
              push_o          = 1'b1;
              push_entry_o.op = Q_STEP;
            end
            CMD_FRAME: begin
              push_o          = 1'b1;
              push_entry_o.op = Q_DROP;
              index_d         = '0;
            end
            default: ;
          endcase
        end
      end
      FS_START: div_start = 1'b1;
      FS_PUSH: begin
        if (index_q == '0) begin
          index_d  = IndexBits'(1);
          prev_x_d = nx_q;
          prev_y_d = ny_q;
        end else if (!q_full_i) begin
          push_o            = 1'b1;
          push_entry_o.op   = Q_ARM;
          push_entry_o.x0   = prev_x_q;
          push_entry_o.y0   = prev_y_q;
          push_entry_o.x1   = nx_q;
          push_entry_o.y1   = ny_q;
          push_entry_o.last = last_sample;
          index_d           = last_sample ? '0 : index_q + 1'b1;
          prev_x_d          = nx_q;
          prev_y_d          = ny_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= FS_IDLE;
      index_q        <= '0;
      prev_x_q       <= '0;
      prev_y_q       <= '0;
      plot_width_q   <= CoordMax;
      plot_height_q  <= CoordMax;
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      min_value_q    <= '0;
      data_range_q   <= '0;
      sample_count_q <= CountBits'(4096);
    end else begin
      state_q  <= state_d;
      index_q  <= index_d;
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_PLOT_WIDTH:   plot_width_q   <= cfg_data_i[CoordBits-1:0];
          REG_PLOT_HEIGHT:  plot_height_q  <= cfg_data_i[CoordBits-1:0];
          REG_ORIGIN_X:     origin_x_q     <= cfg_data_i[CoordBits-1:0];
          REG_ORIGIN_Y:     origin_y_q     <= cfg_data_i[CoordBits-1:0];
          REG_MIN_VALUE:    min_value_q    <= $signed(cfg_data_i);
          REG_DATA_RANGE:   data_range_q   <= cfg_data_i;
          REG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[CountBits-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FS_IDLE) begin
      d_q <= d_new;
    end
    if (state_q == FS_MUL) begin
      prodx_q <= {10'b0, index_q} * {12'b0, plot_width_q};
      prody_q <= {{(DivBits-SampleBits){1'b0}}, d_abs}
               * {{(DivBits-CoordBits){1'b0}}, plot_height_q};
      half_q  <= d_ext * h_ext;
      dneg_q  <= d_q[SampleBits];
    end
    if (state_q == FS_DIV && divx_done && divy_done) begin
      nx_q <= nx_new;
      ny_q <= ny_new;
    end
  end

endmodule

// File: rtl/wlr_back.sv
module wlr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  wlr_pkg::q_entry_t  q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wlr_pkg::out_item_t out_item_o
);
  import wlr_pkg::*;

  logic [CoordBits-1:0]      walk_x_q, walk_x_d, walk_y_q, walk_y_d;
  logic [CoordBits-1:0]      end_x_q, end_x_d, end_y_q, end_y_d;
  logic [CoordBits-1:0]      dx_q, dx_d, dy_q, dy_d;
  logic                      sxn_q, sxn_d, syn_q, syn_d;
  logic signed [ErrBits-1:0] err_q, err_d;
  logic                      active_q, active_d;
  logic                      last_q, last_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  logic                      at_end;
  logic signed [ErrBits:0]   e2;
  logic signed [ErrBits:0]   dx_ext, dy_ext;

  assign at_end  = (walk_x_q == end_x_q) && (walk_y_q == end_y_q);
  assign e2      = {err_q, 1'b0};
  assign dx_ext  = $signed({{(ErrBits+1-CoordBits){1'b0}}, dx_q});
  assign dy_ext  = $signed({{(ErrBits+1-CoordBits){1'b0}}, dy_q});
  assign q_pop_o = q_valid_i && (q_head_i.op != Q_STEP || !out_valid_q || out_ready_i);

  always_comb begin
    walk_x_d    = walk_x_q;
    walk_y_d    = walk_y_q;
    end_x_d     = end_x_q;
    end_y_d     = end_y_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    sxn_d       = sxn_q;
    syn_d       = syn_q;
    err_d       = err_q;
    active_d    = active_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (q_pop_o) begin
      unique case (q_head_i.op)
        Q_DROP: begin
          active_d = 1'b0;
          last_d   = 1'b0;
        end
        Q_ARM: begin
          walk_x_d = q_head_i.x0;
          walk_y_d = q_head_i.y0;
          end_x_d  = q_head_i.x1;
          end_y_d  = q_head_i.y1;
          sxn_d    = !(q_head_i.x0 < q_head_i.x1);
          syn_d    = !(q_head_i.y0 < q_head_i.y1);
          dx_d     = sxn_d ? q_head_i.x0 - q_head_i.x1 : q_head_i.x1 - q_head_i.x0;
          dy_d     = syn_d ? q_head_i.y0 - q_head_i.y1 : q_head_i.y1 - q_head_i.y0;
          err_d    = $signed({{(ErrBits-CoordBits){1'b0}}, dx_d})
                   - $signed({{(ErrBits-CoordBits){1'b0}}, dy_d});
          active_d = 1'b1;
          last_d   = q_head_i.last;
        end
        Q_STEP: begin
          if (active_q) begin
            out_valid_d       = 1'b1;
            out_d.pixel_x     = walk_x_q;
            out_d.pixel_y     = walk_y_q;
            out_d.segment_end = at_end;
            out_d.frame_end   = at_end && last_q;
            if (at_end) begin
              active_d = 1'b0;
              last_d   = 1'b0;
            end else begin
              if (e2 > -dy_ext) begin
                err_d    = err_d - ErrBits'(dy_ext);
                walk_x_d = sxn_q ? walk_x_q - 1'b1 : walk_x_q + 1'b1;
              end
              if (e2 < dx_ext) begin
                err_d    = err_d + ErrBits'(dx_ext);
                walk_y_d = syn_q ? walk_y_q - 1'b1 : walk_y_q + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q    <= '0;
      walk_y_q    <= '0;
      end_x_q     <= '0;
      end_y_q     <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      sxn_q       <= 1'b0;
      syn_q       <= 1'b0;
      err_q       <= '0;
      active_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      walk_x_q    <= walk_x_d;
      walk_y_q    <= walk_y_d;
      end_x_q     <= end_x_d;
      end_y_q     <= end_y_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      sxn_q       <= sxn_d;
      syn_q       <= syn_d;
      err_q       <= err_d;
      active_q    <= active_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/waveform_line_rasterizer.sv
// Waveform plotter: maps samples to canvas pixels and walks the line segments between them.
// Request channel (in_valid_i/in_ready_o/in_item_i) carries a command: sample, step or
// start frame. Pixel channel (out_valid_o/out_ready_i/out_item_o) returns one pixel per
// step request while a segment is armed; steps with no segment armed return nothing.
// Configuration channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i) is always ready;
// the user must write only while no request is in flight, which the block does not enforce.
// A sample request occupies the front end through one multiply stage, then two radix-2
// dividers that run side by side and retire one quotient bit a cycle (26 bits), then the
// coordinate clamp and the hand-off to the segment queue.
// Step and start frame requests are taken one per cycle while no sample is in flight and
// the four-entry segment queue has room; each step's pixel is registered on the output
// register when the walker pops it. The Bresenham walker retires one step per cycle while the
// output register is free or being read. When the receiver stalls, the output register
// holds its pixel, the walker stops, the queue fills, and then in_ready_o drops.
// Reset clears the sample index, drops any armed segment, and loads the plot registers
// with width and height 1023, origin 0, min value 0, data range 0, sample count 4096.
module waveform_line_rasterizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  wlr_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output wlr_pkg::out_item_t              out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [2:0]                      cfg_index_i,
  input  logic [wlr_pkg::SampleBits-1:0]  cfg_data_i
);
  import wlr_pkg::*;

  logic     push;
  q_entry_t push_entry;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;

  assign cfg_ready_o = 1'b1;

  wlr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .q_full_i     (q_full)
  );

  wlr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  wlr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: bench/waveform_line_rasterizer_tb.sv
`timescale 1ns / 100ps

module waveform_line_rasterizer_tb;
  import wlr_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int WalkCap = 40;
  localparam int SettleCycles = 64;
  localparam int LongHold = 400;
  localparam int RequestTarget = 1050;
  localparam int PhaseRequests = 150;
  localparam int ReportLimit = 10;

  typedef enum logic {
    ROW_REQUEST,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    in_item_t              req;
    cfg_reg_e              reg_id;
    logic [SampleBits-1:0] data;
    logic                  typed;
    out_item_t             pixel;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [2:0]            cfg_index_i = '0;
  logic [SampleBits-1:0] cfg_data_i = '0;

  logic [CoordBits-1:0]         plot_w = 10'd1023;
  logic [CoordBits-1:0]         plot_h = 10'd1023;
  logic [CoordBits-1:0]         org_x = '0;
  logic [CoordBits-1:0]         org_y = '0;
  logic signed [SampleBits-1:0] floor_val = '0;
  logic [SampleBits-1:0]        span = '0;
  logic [CountBits-1:0]         frame_len = 13'd4096;

  int smp_idx = 0, prev_x = 0, prev_y = 0, walk_x = 0, walk_y = 0, end_x = 0, end_y = 0;
  int seg_dx = 0, seg_dy = 0, seg_err = 0;
  bit neg_x = 1'b0, neg_y = 1'b0, seg_armed = 1'b0, seg_last = 1'b0;

  out_item_t expected_pixels[$];
  out_item_t last_pixel = '0;
  stim_row_t stim_rows[$];
  int        fail_count = 0;
  int        requests_sent = 0;
  bit        tx_quiet = 1'b0, rx_quiet = 1'b0, long_hold = 1'b0;

  logic [SampleBits-1:0] reg_low[7] = '{16'd1, 16'd1, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd2};
  logic [SampleBits-1:0] reg_high[7] =
    '{16'd1023, 16'd1023, 16'd1023, 16'd1023, 16'h7FFF, 16'hFFFF, 16'd4096};

  waveform_line_rasterizer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int fit_canvas(longint v);
    if (v < 0) return 0;
    if (v > CanvasSize - 1) return CanvasSize - 1;
    return int'(v);
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [SampleBits-1:0] d);
    case (cfg_reg_e'(idx))
      REG_PLOT_WIDTH:   plot_w = d[CoordBits-1:0];
      REG_PLOT_HEIGHT:  plot_h = d[CoordBits-1:0];
      REG_ORIGIN_X:     org_x = d[CoordBits-1:0];
      REG_ORIGIN_Y:     org_y = d[CoordBits-1:0];
      REG_MIN_VALUE:    floor_val = d;
      REG_DATA_RANGE:   span = d;
      REG_SAMPLE_COUNT: frame_len = d[CountBits-1:0];
      default: ;
    endcase
  endfunction

  function automatic void plot_request(in_item_t req);
    longint    sc, px, py, num, q;
    int        nx, ny, e2;
    bit        at_end;
    out_item_t pix;
    case (req.command)
      CMD_FRAME: begin
        smp_idx = 0;
        seg_armed = 1'b0;
        seg_last = 1'b0;
      end
      CMD_SAMPLE: begin
        sc = frame_len < 2 ? 2 : (frame_len > 4096 ? 4096 : longint'(frame_len));
        px = longint'(org_x) + (longint'(smp_idx) * longint'(plot_w)) / sc;
        num = longint'(req.sample_value) - longint'(floor_val);
        if (span == 0) begin
          q = num * longint'(plot_h / 2);
        end else begin
          num = num * longint'(plot_h);
          q = num / longint'(span);
          if (num % longint'(span) != 0 && num < 0) q = q - 1;
        end
        py = longint'(org_y) + longint'(plot_h) - q;
        nx = fit_canvas(px);
        ny = fit_canvas(py);
        if (smp_idx == 0) begin
          smp_idx = 1;
        end else begin
          walk_x = prev_x;
          walk_y = prev_y;
          end_x = nx;
          end_y = ny;
          neg_x = !(prev_x < nx);
          neg_y = !(prev_y < ny);
          seg_dx = nx > prev_x ? nx - prev_x : prev_x - nx;
          seg_dy = ny > prev_y ? ny - prev_y : prev_y - ny;
          seg_err = seg_dx - seg_dy;
          seg_armed = 1'b1;
          if (smp_idx >= sc - 1) begin
            seg_last = 1'b1;
            smp_idx = 0;
          end else begin
            seg_last = 1'b0;
            smp_idx = (smp_idx + 1) & 12'hFFF;
          end
        end
        prev_x = nx;
        prev_y = ny;
      end
      CMD_STEP: begin
        if (seg_armed) begin
          at_end = (walk_x == end_x) && (walk_y == end_y);
          pix.pixel_x = CoordBits'(walk_x);
          pix.pixel_y = CoordBits'(walk_y);
          pix.segment_end = at_end;
          pix.frame_end = at_end && seg_last;
          expected_pixels.push_back(pix);
          if (at_end) begin
            seg_armed = 1'b0;
            seg_last = 1'b0;
          end else begin
            e2 = 2 * seg_err;
            if (e2 > -seg_dy) begin
              seg_err = seg_err - seg_dy;
              walk_x = neg_x ? walk_x - 1 : walk_x + 1;
            end
            if (e2 < seg_dx) begin
              seg_err = seg_err + seg_dx;
              walk_y = neg_y ? walk_y - 1 : walk_y + 1;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_pixel(out_item_t want, out_item_t got);
    if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
        got.segment_end !== want.segment_end || got.frame_end !== want.frame_end) begin
      fail_count++;
      if (fail_count <= ReportLimit)
        $display("pixel mismatch: expected x=%0d y=%0d end=%0b frame_end=%0b,",
                 want.pixel_x, want.pixel_y, want.segment_end, want.frame_end,
                 " got x=%0d y=%0d end=%0b frame_end=%0b",
                 got.pixel_x, got.pixel_y, got.segment_end, got.frame_end);
    end
  endfunction

  function automatic int pick_gap(ref bit quiet);
    if ($urandom_range(0, 29) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic void request_row(logic [1:0] cmd, logic [SampleBits-1:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.req.command = cmd;
    row.req.sample_value = value;
    stim_rows.push_back(row);
  endfunction

  function automatic void pixel_row(int x, int y, bit seg_end, bit frm_end);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.req.command = CMD_STEP;
    row.typed = 1'b1;
    row.pixel.pixel_x = CoordBits'(x);
    row.pixel.pixel_y = CoordBits'(y);
    row.pixel.segment_end = seg_end;
    row.pixel.frame_end = frm_end;
    stim_rows.push_back(row);
  endfunction

  function automatic void write_row(cfg_reg_e r, logic [SampleBits-1:0] d);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_id = r;
    row.data = d;
    stim_rows.push_back(row);
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [SampleBits-1:0] value);
    int       gap;
    in_item_t item;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item.command = cmd;
    item.sample_value = value;
    in_valid_i <= 1'b1;
    in_item_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd != CmdUnused) requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [SampleBits-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        last_pixel = out_item_o;
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit)
            $display("unexpected pixel x=%0d y=%0d end=%0b frame_end=%0b",
                     out_item_o.pixel_x, out_item_o.pixel_y,
                     out_item_o.segment_end, out_item_o.frame_end);
        end else begin
          check_pixel(expected_pixels.pop_front(), out_item_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) plot_request(in_item_i);
    end
  end

  initial begin
    int gap;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      gap = long_hold ? LongHold : pick_gap(rx_quiet);
      long_hold = 1'b0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [SampleBits-1:0] value;
    logic [SampleBits-1:0] last_value;
    logic [SampleBits-1:0] d;
    int                    phase;
    int                    phase_end;
    int                    roll;
    int                    steps;

    last_value = '0;
    phase = 0;

    request_row(CMD_STEP, 16'h0000);
    request_row(CMD_SAMPLE, 16'h0000);
    request_row(CMD_SAMPLE, 16'h0000);
    pixel_row(0, 1023, 1'b1, 1'b0);
    request_row(CMD_STEP, 16'hFFFF);
    request_row(CMD_SAMPLE, 16'h7FFF);
    pixel_row(0, 1023, 1'b0, 1'b0);
    pixel_row(0, 1022, 1'b0, 1'b0);
    request_row(CMD_SAMPLE, 16'h8000);
    pixel_row(0, 0, 1'b0, 1'b0);
    request_row(CmdUnused, 16'hFFFF);
    request_row(CMD_FRAME, 16'h5555);
    request_row(CMD_STEP, 16'hAAAA);
    write_row(REG_PLOT_WIDTH, 16'd1023);
    write_row(REG_PLOT_HEIGHT, 16'd1);
    write_row(REG_ORIGIN_X, 16'd1023);
    write_row(REG_ORIGIN_Y, 16'd1023);
    write_row(REG_MIN_VALUE, 16'h8000);
    write_row(REG_DATA_RANGE, 16'hFFFF);
    write_row(REG_SAMPLE_COUNT, 16'd0);
    request_row(CMD_SAMPLE, 16'h7FFF);
    request_row(CMD_SAMPLE, 16'h8000);
    pixel_row(1023, 1023, 1'b1, 1'b1);
    request_row(CMD_STEP, 16'h0000);

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_WRITE) begin
        if (r == 0 || stim_rows[r-1].kind != ROW_WRITE) wait_quiet();
        write_reg(stim_rows[r].reg_id, stim_rows[r].data);
      end else begin
        send_request(stim_rows[r].req.command, stim_rows[r].req.sample_value);
        if (stim_rows[r].typed) begin
          in_valid_i <= 1'b0;
          @(negedge clk_i);
          while (expected_pixels.size() != 0) @(negedge clk_i);
          check_pixel(stim_rows[r].pixel, last_pixel);
        end
      end
    end

    while (requests_sent < RequestTarget) begin
      wait_quiet();
      for (int i = 0; i < 7; i++) begin
        case (phase == 0 ? 0 : (phase == 1 ? 1 : $urandom_range(0, 3)))
          0: d = reg_low[i];
          1: d = reg_high[i];
          2: d = SampleBits'($urandom);
          default: d = (i == REG_SAMPLE_COUNT) ? SampleBits'($urandom_range(0, 40))
                                               : SampleBits'($urandom_range(0, 1023));
        endcase
        write_reg(cfg_reg_e'(i), d);
      end
      if (phase == 2) long_hold = 1'b1;
      if ($urandom_range(0, 3) != 0) send_request(CMD_FRAME, SampleBits'($urandom));
      phase_end = requests_sent + PhaseRequests;
      while (requests_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 82) begin
          case ($urandom_range(0, 5))
            0: value = SampleBits'($urandom);
            1: value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: value = last_value + 16'($urandom_range(0, 40)) - 16'd20;
          endcase
          last_value = value;
          send_request(CMD_SAMPLE, value);
          steps = seg_armed ? ((seg_dx > seg_dy ? seg_dx : seg_dy) + 1) : 0;
          if (steps > WalkCap) steps = $urandom_range(1, WalkCap);
          else if ($urandom_range(0, 7) == 0) steps = steps + $urandom_range(0, 2) - 1;
          repeat (steps) send_request(CMD_STEP, SampleBits'($urandom));
        end else if (roll < 90) begin
          send_request(CMD_STEP, SampleBits'($urandom));
        end else if (roll < 95) begin
          send_request(CMD_FRAME, SampleBits'($urandom));
        end else begin
          send_request(CmdUnused, SampleBits'($urandom));
        end
      end
      phase++;
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
